// ===== rtl/tgad_pkg.sv =====
// Shared types, constants and status codes of the TGA truecolour stream decoder.
package tgad_pkg;

	localparam int HEADER_BYTES = 18;
	localparam int DIM_BITS_DEF = 16;
	localparam int QUEUE_DEPTH  = 4;
	localparam int CFG_IDX_BITS = 2;

	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_HEIGHT = 2'd1;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_SHORT = 3'd1;
	localparam logic [2:0] ST_TYPE  = 3'd2;
	localparam logic [2:0] ST_CMAP  = 3'd3;
	localparam logic [2:0] ST_SIZE  = 3'd4;
	localparam logic [2:0] ST_DEPTH = 3'd5;
	localparam logic [2:0] ST_TRUNC = 3'd6;

	localparam logic KIND_PIXEL  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_file;
	} tgad_in_t;

	typedef struct packed {
		logic        result_kind;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [15:0] pixel_row;
		logic [15:0] pixel_col;
		logic [2:0]  status_code;
		logic        last_result;
	} tgad_out_t;

	typedef struct packed {
		logic        pix_valid;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [15:0] row;
		logic [15:0] col;
		logic        stat_valid;
		logic [2:0]  status;
	} tgad_entry_t;

	typedef struct packed {
		logic full;
		logic nempty;
	} tgad_qstat_t;

endpackage

// ===== rtl/tga_truecolor_stream_decoder_top.sv =====
// Top level of the TGA truecolour stream decoder.
// Takes one file byte per transfer and accepts a byte in every cycle while the
// four-entry command queue has room; each byte is parsed combinationally by the
// front end. The back end delivers one result per cycle while out_stall is low,
// from its output register, so a byte that both completes a pixel and ends the
// file yields two results, which the queue absorbs. Pixel results follow the
// file as it arrives; on the final byte a status result with last_result set
// closes the file, after which the decoder is ready for the next file at once.
module tga_truecolor_stream_decoder_top #(
	parameter int DIM_BITS = tgad_pkg::DIM_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  tgad_pkg::tgad_in_t                in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output tgad_pkg::tgad_out_t               out_data,
	input  logic                              cfg_en,
	input  logic [tgad_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [15:0]                       cfg_data
);
	import tgad_pkg::*;

	logic        accept;
	logic        push;
	logic        pop;
	tgad_entry_t wr_entry;
	tgad_entry_t head;
	tgad_qstat_t qstat;

	assign in_stall = qstat.full;
	assign accept   = in_valid && !in_stall;

	tgad_front #(
		.DIM_BITS(DIM_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.in_data  (in_data),
		.cfg_en   (cfg_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.push     (push),
		.entry    (wr_entry)
	);

	tgad_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_entry(wr_entry),
		.pop     (pop),
		.head    (head),
		.qstat   (qstat)
	);

	tgad_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.qstat    (qstat),
		.pop      (pop),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_data (out_data)
	);

endmodule

// ===== rtl/tgad_front.sv =====
// Front end: header parser, pixel assembler and position counters.
module tgad_front #(
	parameter int DIM_BITS = tgad_pkg::DIM_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   accept,
	input  tgad_pkg::tgad_in_t                     in_data,
	input  logic                                   cfg_en,
	input  logic [tgad_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [15:0]                            cfg_data,
	output logic                                   push,
	output tgad_pkg::tgad_entry_t                  entry
);
	import tgad_pkg::*;

	typedef enum logic [4:0] {
		PH_HEADER = 5'b00001,
		PH_ID     = 5'b00010,
		PH_PIXELS = 5'b00100,
		PH_DONE   = 5'b01000,
		PH_FAULT  = 5'b10000
	} phase_t;

	localparam logic [4:0] HB_ID_LEN = 5'd0;
	localparam logic [4:0] HB_CMAP   = 5'd1;
	localparam logic [4:0] HB_TYPE   = 5'd2;
	localparam logic [4:0] HB_W_LO   = 5'd12;
	localparam logic [4:0] HB_W_HI   = 5'd13;
	localparam logic [4:0] HB_H_LO   = 5'd14;
	localparam logic [4:0] HB_H_HI   = 5'd15;
	localparam logic [4:0] HB_DEPTH  = 5'd16;
	localparam logic [4:0] HB_LAST   = 5'(HEADER_BYTES - 1);
	localparam logic [7:0] IMG_TRUECOLOR = 8'd2;
	localparam logic [7:0] DEPTH_24 = 8'd24;
	localparam logic [7:0] DEPTH_32 = 8'd32;

	phase_t              phase_q, phase_n;
	logic [4:0]          hidx_q, hidx_n;
	logic [7:0]          id_left_q, id_left_n;
	logic [7:0]          type_q, type_n;
	logic [7:0]          cmap_q, cmap_n;
	logic [15:0]         width_q, width_n;
	logic [15:0]         height_q, height_n;
	logic                four_q, four_n;
	logic                origin_q, origin_n;
	logic [1:0]          pbi_q, pbi_n;
	logic [7:0]          blue_q, blue_n;
	logic [7:0]          green_q, green_n;
	logic [DIM_BITS-1:0] col_q, col_n;
	logic [DIM_BITS-1:0] row_q, row_n;
	logic [DIM_BITS-1:0] rows_q, rows_n;
	logic [2:0]          err_q, err_n;
	logic [15:0]         max_w_q, max_h_q;

	logic [7:0]          b;
	logic                eof;
	logic [DIM_BITS-1:0] h_last;
	logic [DIM_BITS-1:0] col_inc, rows_inc;
	logic [1:0]          last_idx;
	logic [2:0]          status;

	function automatic logic dim_ok(input logic [15:0] d, input logic [15:0] lim);
		logic [15:0] hi;
		hi = d >> DIM_BITS;
		return (d != 16'd0) && (d <= lim) && (hi == 16'd0);
	endfunction

	assign b        = in_data.data_byte;
	assign eof      = in_data.end_of_file;
	assign h_last   = height_q[DIM_BITS-1:0] - 1'b1;
	assign col_inc  = col_q + 1'b1;
	assign rows_inc = rows_q + 1'b1;
	assign last_idx = four_q ? 2'd3 : 2'd2;

	always_comb begin
		phase_n   = phase_q;
		hidx_n    = hidx_q;
		id_left_n = id_left_q;
		type_n    = type_q;
		cmap_n    = cmap_q;
		width_n   = width_q;
		height_n  = height_q;
		four_n    = four_q;
		origin_n  = origin_q;
		pbi_n     = pbi_q;
		blue_n    = blue_q;
		green_n   = green_q;
		col_n     = col_q;
		row_n     = row_q;
		rows_n    = rows_q;
		err_n     = err_q;
		status    = ST_OK;
		entry     = '0;
		unique case (phase_q)
			PH_HEADER: begin
				unique case (hidx_q)
					HB_ID_LEN: id_left_n = b;
					HB_CMAP:   cmap_n = b;
					HB_TYPE:   type_n = b;
					HB_W_LO:   width_n = {8'd0, b};
					HB_W_HI:   width_n = {b, width_q[7:0]};
					HB_H_LO:   height_n = {8'd0, b};
					HB_H_HI:   height_n = {b, height_q[7:0]};
					HB_DEPTH: begin
						four_n = (b == DEPTH_32);
						priority if (type_q != IMG_TRUECOLOR) err_n = ST_TYPE;
						else if (cmap_q != 8'd0) err_n = ST_CMAP;
						else if (!dim_ok(width_q, max_w_q) || !dim_ok(height_q, max_h_q))
							err_n = ST_SIZE;
						else if (b != DEPTH_24 && b != DEPTH_32) err_n = ST_DEPTH;
						else err_n = ST_OK;
					end
					HB_LAST:   origin_n = b[5];
					default:   ;
				endcase
				if (hidx_q == HB_LAST) begin
					hidx_n = '0;
					priority if (err_q != ST_OK) phase_n = PH_FAULT;
					else if (id_left_q != 8'd0) phase_n = PH_ID;
					else begin
						phase_n = PH_PIXELS;
						row_n   = b[5] ? '0 : h_last;
					end
					status = (err_q != ST_OK) ? err_q : ST_TRUNC;
				end else begin
					hidx_n = hidx_q + 1'b1;
					status = ST_SHORT;
				end
			end
			PH_ID: begin
				id_left_n = id_left_q - 1'b1;
				if (id_left_q == 8'd1) begin
					phase_n = PH_PIXELS;
					row_n   = origin_q ? '0 : h_last;
				end
				status = ST_TRUNC;
			end
			PH_PIXELS: begin
				unique case (pbi_q)
					2'd0: blue_n = b;
					2'd1: green_n = b;
					2'd2: begin
						entry.pix_valid = 1'b1;
						entry.red       = b;
						entry.green     = green_q;
						entry.blue      = blue_q;
						entry.row       = 16'(row_q);
						entry.col       = 16'(col_q);
					end
					default: ;
				endcase
				if (pbi_q >= last_idx) begin
					pbi_n = '0;
					col_n = col_inc;
					if (16'(col_inc) >= width_q) begin
						col_n  = '0;
						rows_n = rows_inc;
						if (16'(rows_inc) >= height_q) phase_n = PH_DONE;
						else row_n = origin_q ? rows_inc : (h_last - rows_inc);
					end
				end else begin
					pbi_n = pbi_q + 1'b1;
				end
				status = (phase_n == PH_DONE) ? ST_OK : ST_TRUNC;
			end
			PH_DONE:  status = ST_OK;
			PH_FAULT: status = err_q;
			default:  status = err_q;
		endcase
		entry.stat_valid = eof;
		entry.status     = status;
		if (eof) begin
			phase_n = PH_HEADER;
			hidx_n  = '0;
			pbi_n   = '0;
			col_n   = '0;
			rows_n  = '0;
			err_n   = ST_OK;
		end
	end

	assign push = accept && (entry.pix_valid || entry.stat_valid);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hidx_q  <= '0;
			pbi_q   <= '0;
			col_q   <= '0;
			rows_q  <= '0;
			err_q   <= ST_OK;
			max_w_q <= 16'hFFFF;
			max_h_q <= 16'hFFFF;
		end else begin
			if (accept) begin
				phase_q <= phase_n;
				hidx_q  <= hidx_n;
				pbi_q   <= pbi_n;
				col_q   <= col_n;
				rows_q  <= rows_n;
				err_q   <= err_n;
			end
			if (cfg_en && cfg_index == REG_MAX_WIDTH) max_w_q <= cfg_data;
			if (cfg_en && cfg_index == REG_MAX_HEIGHT) max_h_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			id_left_q <= id_left_n;
			type_q    <= type_n;
			cmap_q    <= cmap_n;
			width_q   <= width_n;
			height_q  <= height_n;
			four_q    <= four_n;
			origin_q  <= origin_n;
			blue_q    <= blue_n;
			green_q   <= green_n;
			row_q     <= row_n;
		end
	end

endmodule

// ===== rtl/tgad_queue.sv =====
// Short command queue between the front end and the back end.
module tgad_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  tgad_pkg::tgad_entry_t wr_entry,
	input  logic                  pop,
	output tgad_pkg::tgad_entry_t head,
	output tgad_pkg::tgad_qstat_t qstat
);
	import tgad_pkg::*;

	localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	tgad_entry_t         mem_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;

	assign head         = mem_q[rd_ptr_q];
	assign qstat.full   = (count_q == CNT_BITS'(QUEUE_DEPTH));
	assign qstat.nempty = (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= (rd_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_entry;
	end

endmodule

// ===== rtl/tgad_back.sv =====
// Back end: expands queued commands into pixel and status results.
module tgad_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tgad_pkg::tgad_entry_t head,
	input  tgad_pkg::tgad_qstat_t qstat,
	output logic                  pop,
	input  logic                  out_stall,
	output logic                  out_valid,
	output tgad_pkg::tgad_out_t   out_data
);
	import tgad_pkg::*;

	logic      out_valid_q;
	tgad_out_t out_q;
	logic      pix_done_q;
	logic      load;
	logic      take_pix;
	tgad_out_t res;

	assign load     = !out_valid_q || !out_stall;
	assign take_pix = head.pix_valid && !pix_done_q;
	assign pop      = load && qstat.nempty && (!take_pix || !head.stat_valid);

	always_comb begin
		res = '0;
		if (take_pix) begin
			res.result_kind = KIND_PIXEL;
			res.red         = head.red;
			res.green       = head.green;
			res.blue        = head.blue;
			res.pixel_row   = head.row;
			res.pixel_col   = head.col;
		end else begin
			res.result_kind = KIND_STATUS;
			res.status_code = head.status;
			res.last_result = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pix_done_q  <= 1'b0;
		end else if (load) begin
			out_valid_q <= qstat.nempty;
			if (qstat.nempty) pix_done_q <= take_pix && head.stat_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && qstat.nempty) out_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== bench/tga_truecolor_stream_decoder_top_tb.sv =====
// Self-checking bench for the TGA truecolour stream decoder: scripted and random files.
`timescale 1ns / 1ps

module tga_truecolor_stream_decoder_top_tb;
	import tgad_pkg::*;

	localparam int unsigned RUN_LIMIT = 400000;
	localparam int unsigned SETTLE_CYCLES = 20;
	localparam logic [7:0] TGA_TRUECOLOUR = 8'd2;
	localparam logic [7:0] DEPTH_24 = 8'd24;
	localparam logic [7:0] DEPTH_32 = 8'd32;

	typedef enum logic [2:0] {PH_HEADER, PH_ID, PH_PIXELS, PH_DONE, PH_FAULT} dec_phase_e;

	typedef struct packed {
		tgad_in_t   x;
		logic       typed;
		logic [2:0] st;
	} feed_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	tgad_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	tgad_out_t out_data;
	logic cfg_en = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	feed_t file_bytes[$];
	tgad_out_t due_results[$];
	feed_t on_wire;
	logic hold_feed = 1'b0;
	int idle_mode = 0;
	int send_calm = 0;
	int recv_calm = 0;
	int mismatches = 0;
	int unsigned cycle_count = 0;

	logic [15:0] lim_w = 16'hFFFF;
	logic [15:0] lim_h = 16'hFFFF;
	dec_phase_e dec_phase = PH_HEADER;
	logic [4:0] hdr_idx = '0;
	logic [7:0] id_left = '0;
	logic [7:0] type_seen = '0;
	logic [7:0] cmap_seen = '0;
	logic [15:0] img_w = '0;
	logic [15:0] img_h = '0;
	logic quad_px = 1'b0;
	logic top_origin = 1'b0;
	logic [1:0] px_idx = '0;
	logic [7:0] held_b = '0;
	logic [7:0] held_g = '0;
	logic [15:0] col_pos = '0;
	logic [15:0] row_pos = '0;
	logic [15:0] rows_seen = '0;
	logic [2:0] fault_code = ST_OK;

	int unsigned lim_w_set[8] = '{65535, 65535, 1, 0, 4, 3, 1, 1};
	int unsigned lim_h_set[8] = '{65535, 65535, 1, 3, 65535, 2, 1, 1};

	feed_t directed_rows[24] = '{
		'{'{8'h00, 1'b1}, 1'b1, ST_SHORT},
		'{'{8'h01, 1'b0}, 1'b0, ST_OK},
		'{'{8'h00, 1'b0}, 1'b0, ST_OK},
		'{'{8'h02, 1'b0}, 1'b0, ST_OK},
		'{'{8'hFF, 1'b0}, 1'b0, ST_OK},
		'{'{8'hFF, 1'b0}, 1'b0, ST_OK},
		'{'{8'hFF, 1'b0}, 1'b0, ST_OK},
		'{'{8'hFF, 1'b0}, 1'b0, ST_OK},
		'{'{8'hFF, 1'b0}, 1'b0, ST_OK},
		'{'{8'h00, 1'b0}, 1'b0, ST_OK},
		'{'{8'h00, 1'b0}, 1'b0, ST_OK},
		'{'{8'h00, 1'b0}, 1'b0, ST_OK},
		'{'{8'h00, 1'b0}, 1'b0, ST_OK},
		'{'{8'h01, 1'b0}, 1'b0, ST_OK},
		'{'{8'h00, 1'b0}, 1'b0, ST_OK},
		'{'{8'h01, 1'b0}, 1'b0, ST_OK},
		'{'{8'h00, 1'b0}, 1'b0, ST_OK},
		'{'{8'h20, 1'b0}, 1'b0, ST_OK},
		'{'{8'h00, 1'b0}, 1'b0, ST_OK},
		'{'{8'hA5, 1'b0}, 1'b0, ST_OK},
		'{'{8'h00, 1'b0}, 1'b0, ST_OK},
		'{'{8'hFF, 1'b0}, 1'b0, ST_OK},
		'{'{8'h80, 1'b0}, 1'b0, ST_OK},
		'{'{8'hFF, 1'b1}, 1'b1, ST_OK}
	};

	tga_truecolor_stream_decoder_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_en(cfg_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic tgad_out_t status_result(logic [2:0] code);
		tgad_out_t r;
		r = '0;
		r.result_kind = KIND_STATUS;
		r.status_code = code;
		r.last_result = 1'b1;
		return r;
	endfunction

	function automatic logic [15:0] flip_row(logic [15:0] src);
		return top_origin ? src : img_h - 16'd1 - src;
	endfunction

	function automatic logic dim_fits(logic [15:0] d, logic [15:0] lim);
		return d != 16'd0 && d <= lim;
	endfunction

	function automatic void clear_file();
		dec_phase = PH_HEADER;
		hdr_idx = '0;
		id_left = '0;
		type_seen = '0;
		cmap_seen = '0;
		img_w = '0;
		img_h = '0;
		quad_px = 1'b0;
		top_origin = 1'b0;
		px_idx = '0;
		held_b = '0;
		held_g = '0;
		col_pos = '0;
		row_pos = '0;
		rows_seen = '0;
		fault_code = ST_OK;
	endfunction

	function automatic void decode_byte(tgad_in_t x);
		logic [7:0] b;
		logic [2:0] st;
		logic [1:0] last_idx;
		tgad_out_t px;
		b = x.data_byte;
		st = ST_OK;
		case (dec_phase)
			PH_HEADER: begin
				case (hdr_idx)
					5'd0: id_left = b;
					5'd1: cmap_seen = b;
					5'd2: type_seen = b;
					5'd12: img_w = {8'd0, b};
					5'd13: img_w[15:8] = b;
					5'd14: img_h = {8'd0, b};
					5'd15: img_h[15:8] = b;
					5'd16: begin
						quad_px = (b == DEPTH_32);
						if (type_seen != TGA_TRUECOLOUR) fault_code = ST_TYPE;
						else if (cmap_seen != 8'd0) fault_code = ST_CMAP;
						else if (!dim_fits(img_w, lim_w) || !dim_fits(img_h, lim_h))
							fault_code = ST_SIZE;
						else if (b != DEPTH_24 && b != DEPTH_32) fault_code = ST_DEPTH;
						else fault_code = ST_OK;
					end
					5'd17: top_origin = b[5];
					default: ;
				endcase
				if (hdr_idx == 5'(HEADER_BYTES - 1)) begin
					hdr_idx = '0;
					if (fault_code != ST_OK) dec_phase = PH_FAULT;
					else if (id_left != 8'd0) dec_phase = PH_ID;
					else begin
						dec_phase = PH_PIXELS;
						row_pos = flip_row(16'd0);
					end
					if (x.end_of_file) st = (fault_code != ST_OK) ? fault_code : ST_TRUNC;
				end else begin
					hdr_idx = hdr_idx + 5'd1;
					if (x.end_of_file) st = ST_SHORT;
				end
			end
			PH_ID: begin
				id_left = id_left - 8'd1;
				if (id_left == 8'd0) begin
					dec_phase = PH_PIXELS;
					row_pos = flip_row(16'd0);
				end
				if (x.end_of_file) st = ST_TRUNC;
			end
			PH_PIXELS: begin
				last_idx = quad_px ? 2'd3 : 2'd2;
				case (px_idx)
					2'd0: held_b = b;
					2'd1: held_g = b;
					2'd2: begin
						px = '0;
						px.result_kind = KIND_PIXEL;
						px.red = b;
						px.green = held_g;
						px.blue = held_b;
						px.pixel_row = row_pos;
						px.pixel_col = col_pos;
						due_results.push_back(px);
					end
					default: ;
				endcase
				if (px_idx >= last_idx) begin
					px_idx = '0;
					col_pos = col_pos + 16'd1;
					if (col_pos >= img_w) begin
						col_pos = '0;
						rows_seen = rows_seen + 16'd1;
						if (rows_seen >= img_h) dec_phase = PH_DONE;
						else row_pos = flip_row(rows_seen);
					end
				end else begin
					px_idx = px_idx + 2'd1;
				end
				if (x.end_of_file) st = (dec_phase == PH_DONE) ? ST_OK : ST_TRUNC;
			end
			PH_DONE: st = ST_OK;
			default: st = fault_code;
		endcase
		if (x.end_of_file) begin
			due_results.push_back(status_result(st));
			clear_file();
		end
	endfunction

	function automatic string show(tgad_out_t r);
		return $sformatf("kind=%0d rgb=%02h/%02h/%02h row=%0d col=%0d status=%0d last=%0d",
			r.result_kind, r.red, r.green, r.blue, r.pixel_row, r.pixel_col,
			r.status_code, r.last_result);
	endfunction

	function automatic void check_result(tgad_out_t got);
		tgad_out_t want;
		logic bad;
		logic none_due;
		want = '0;
		none_due = (due_results.size() == 0);
		bad = 1'b1;
		if (!none_due) begin
			want = due_results.pop_front();
			bad = got.result_kind !== want.result_kind || got.red !== want.red ||
				got.green !== want.green || got.blue !== want.blue ||
				got.pixel_row !== want.pixel_row || got.pixel_col !== want.pixel_col ||
				got.status_code !== want.status_code || got.last_result !== want.last_result;
		end
		if (bad) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch at cycle %0d (nothing due: %0d): expected %s, got %s",
					cycle_count, none_due, show(want), show(got));
		end
	endfunction

	function automatic logic roll_idle(int pct, inout int calm);
		if (pct == 0) return 1'b0;
		if (calm > 0) begin
			calm--;
			return 1'b0;
		end
		if ($urandom_range(99) == 0) calm = $urandom_range(20, 60);
		return $urandom_range(99) < pct;
	endfunction

	function automatic int unsigned pick_dim(logic [15:0] lim);
		if (lim == 16'd0) return $urandom_range(1, 4);
		if ($urandom_range(24) == 0) return lim;
		return $urandom_range(1, (lim < 16'd4) ? lim : 4);
	endfunction

	task automatic queue_file();
		logic [7:0] f[$];
		feed_t e;
		int kind, idlen, cut;
		int unsigned w, h;
		longint pix_bytes;
		logic [7:0] type_b, cmap_b, depth;
		logic cut_short;
		kind = $urandom_range(99);
		cut_short = ($urandom_range(5) == 0);
		if (kind < 8) begin
			repeat ($urandom_range(1, 30)) f.push_back(8'($urandom));
		end else begin
			w = pick_dim(lim_w);
			h = pick_dim(lim_h);
			type_b = TGA_TRUECOLOUR;
			cmap_b = 8'd0;
			depth = $urandom_range(1) ? DEPTH_32 : DEPTH_24;
			if ($urandom_range(9) == 0) idlen = $urandom_range(255);
			else idlen = ($urandom_range(2) == 0) ? $urandom_range(1, 4) : 0;
			if (kind < 30) begin
				case ($urandom_range(5))
					0: begin
						type_b = 8'($urandom);
						if (type_b == TGA_TRUECOLOUR) type_b = 8'd10;
					end
					1: cmap_b = 8'($urandom_range(1, 255));
					2: w = (lim_w < 16'hFFFF && $urandom_range(1)) ? lim_w + 1 : 0;
					3: h = (lim_h < 16'hFFFF && $urandom_range(1)) ? lim_h + 1 : 0;
					4: begin
						depth = 8'($urandom);
						if (depth == DEPTH_24 || depth == DEPTH_32) depth = 8'd16;
					end
					default: begin
						type_b = 8'($urandom);
						cmap_b = 8'($urandom);
						w = $urandom_range(65535);
						h = $urandom_range(65535);
						depth = 8'($urandom);
					end
				endcase
			end
			f.push_back(8'(idlen));
			f.push_back(cmap_b);
			f.push_back(type_b);
			repeat (9) f.push_back(8'($urandom));
			f.push_back(w[7:0]);
			f.push_back(w[15:8]);
			f.push_back(h[7:0]);
			f.push_back(h[15:8]);
			f.push_back(depth);
			f.push_back(8'($urandom));
			repeat (idlen) f.push_back(8'($urandom));
			pix_bytes = longint'(w) * longint'(h) * ((depth == DEPTH_32) ? 4 : 3);
			if (pix_bytes > 240) begin
				pix_bytes = $urandom_range(240);
				cut_short = 1'b1;
			end
			repeat (int'(pix_bytes)) f.push_back(8'($urandom));
			if (!cut_short && $urandom_range(3) == 0)
				repeat ($urandom_range(1, 3)) f.push_back(8'($urandom));
		end
		if (cut_short) begin
			cut = $urandom_range(1, f.size());
			while (f.size() > cut) void'(f.pop_back());
		end
		foreach (f[k]) begin
			e.x.data_byte = f[k];
			e.x.end_of_file = (k == f.size() - 1);
			e.typed = 1'b0;
			e.st = ST_OK;
			file_bytes.push_back(e);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_en <= 1'b0;
		if (idx == REG_MAX_WIDTH) lim_w = val;
		else lim_h = val;
	endtask

	task automatic settle();
		while (file_bytes.size() != 0 || in_valid || due_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// sender: advance on each transfer, hold the payload while stalled
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				decode_byte(on_wire.x);
				if (on_wire.typed) begin
					void'(due_results.pop_back());
					due_results.push_back(status_result(on_wire.st));
				end
			end
			if (!in_valid || !in_stall) begin
				if (file_bytes.size() != 0 && !hold_feed &&
						!roll_idle((idle_mode == 1) ? 83 : (idle_mode == 3) ? 35 : 0, send_calm)) begin
					on_wire = file_bytes.pop_front();
					in_valid <= 1'b1;
					in_data <= on_wire.x;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) check_result(out_data);
			out_stall <= roll_idle((idle_mode == 2) ? 83 : (idle_mode == 3) ? 35 : 0, recv_calm);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > RUN_LIMIT) begin
			$display("[tga_truecolor_stream_decoder_top] ERROR");
			$finish;
		end
	end

	initial begin
		int ph, quota, half;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		for (ph = 0; ph < 8; ph++) begin
			if (ph != 0) begin
				settle();
				write_reg(REG_MAX_WIDTH, (ph >= 6) ? 16'($urandom_range(1, 8)) : 16'(lim_w_set[ph]));
				write_reg(REG_MAX_HEIGHT, (ph >= 6) ? 16'($urandom_range(1, 8)) : 16'(lim_h_set[ph]));
			end
			@(negedge clk);
			idle_mode = ph % 4;
			if (ph == 0)
				foreach (directed_rows[k]) file_bytes.push_back(directed_rows[k]);
			quota = file_bytes.size() + 115;
			while (file_bytes.size() < quota) queue_file();
			if (ph == 1) begin
				half = file_bytes.size() / 2;
				while (file_bytes.size() > half) @(negedge clk);
				// hold the feed until the decoder has delivered everything owed
				hold_feed <= 1'b1;
				@(negedge clk);
				while (in_valid || due_results.size() != 0) @(negedge clk);
				hold_feed <= 1'b0;
			end
		end
		settle();
		if (due_results.size() != 0) mismatches++;
		if (mismatches == 0)
			$display("[tga_truecolor_stream_decoder_top] OK");
		else
			$display("[tga_truecolor_stream_decoder_top] ERROR");
		$finish;
	end

endmodule
